/* src/fmcu_pkg.sv */
// fmcu_pkg: shared types and character constants for the feed message csv unpacker
// no dependencies
`timescale 1ns / 1ps

package fmcu_pkg;

    // characters used in the csv text
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_ONE     = 8'h31;
    localparam logic [7:0] CHAR_TWO     = 8'h32;
    localparam logic [7:0] CHAR_A       = 8'h41;
    localparam logic [7:0] CHAR_D       = 8'h44;
    localparam logic [3:0] DIGIT_BASE   = 4'h3;

    // characters per input byte and queue size
    localparam int MAX_CHARS   = 4;
    localparam int QUEUE_DEPTH = 2;

    // one run of characters caused by one input byte
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0]         chars;
        logic [$clog2(MAX_CHARS)-1:0]      last_idx;
        logic [1:0]                        stream;
    } cmd_t;

endpackage

/* src/fmcu_in_if.sv */
// fmcu_in_if: input byte channel, valid/ready handshake
// no dependencies
`timescale 1ns / 1ps

interface fmcu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

/* src/fmcu_out_if.sv */
// fmcu_out_if: output character channel, valid/ready handshake
// no dependencies
`timescale 1ns / 1ps

interface fmcu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic [1:0] stream_select;
    logic       last_of_run;

    modport source (output valid, output out_char, output stream_select,
                    output last_of_run, input ready);
    modport sink (input valid, input out_char, input stream_select,
                  input last_of_run, output ready);
endinterface

/* src/fmcu_front.sv */
// fmcu_front: accepts payload bytes, tracks the message layout and builds character runs
// depends on fmcu_pkg and fmcu_in_if
`timescale 1ns / 1ps

module fmcu_front
    import fmcu_pkg::*;
#(
    parameter int POSITION_BITS = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    fmcu_in_if.sink         in_ch,
    output cmd_t            cmd,
    output logic            cmd_valid,
    input  logic            cmd_ready
);

    typedef enum logic [1:0] {
        CLS_NONE    = 2'd0,
        CLS_PRODUCT = 2'd1,
        CLS_BOOK    = 2'd2,
        CLS_TRADE   = 2'd3
    } class_t;

    typedef enum logic [1:0] {
        SEC_HEAD    = 2'd0,
        SEC_GROUPS  = 2'd1,
        SEC_TRAILER = 2'd2,
        SEC_DONE    = 2'd3
    } section_t;

    typedef enum logic [2:0] {
        K_NONE,
        K_RAW,
        K_RAW_COMMA,
        K_SIGN_COMMA,
        K_BCD,
        K_BCD_COMMA
    } kind_t;

    typedef logic [POSITION_BITS-1:0] pos_t;

    localparam pos_t POS_MAX = '1;

    pos_t       pos_reg, pos_next;
    class_t     class_reg, class_next;
    logic [7:0] tag_reg, tag_next;
    logic [7:0] groups_reg, groups_next;
    logic [3:0] goff_reg, goff_next;
    section_t   section_reg, section_next;
    logic [3:0] toff_reg, toff_next;

    kind_t      kind;
    logic [7:0] b;
    pos_t       p;
    logic       accept;
    logic [2:0] n_chars;
    cmd_t       cmd_build;
    logic [7:0] book_count;
    class_t     class_now;

    function automatic logic at(input pos_t pp, input int unsigned v);
        at = (pp == pos_t'(v));
    endfunction

    function automatic logic in_range(input pos_t pp, input int unsigned lo,
                                      input int unsigned hi);
        in_range = (pp >= pos_t'(lo)) && (pp <= pos_t'(hi));
    endfunction

    // bytes 19..43 shared by book and trade headers
    function automatic kind_t common_kind(input pos_t pp);
        kind_t k;
        k = K_NONE;
        if (in_range(pp, 19, 38))
            k = at(pp, 38) ? K_RAW_COMMA : K_RAW;
        else if (in_range(pp, 39, 43))
            k = at(pp, 43) ? K_BCD_COMMA : K_BCD;
        return k;
    endfunction

    // last byte of each 5-byte product bcd field
    function automatic logic product_comma(input pos_t pp);
        product_comma = at(pp, 33) || at(pp, 38) || at(pp, 43) || at(pp, 48)
                     || at(pp, 53) || at(pp, 58) || at(pp, 63);
    endfunction

    // class decided at byte 2 before the end-of-message clear
    function automatic class_t class_after_tag(input logic [7:0] t, input logic [7:0] c);
        class_t r;
        r = CLS_NONE;
        if (t == CHAR_ONE && c == CHAR_ONE)
            r = CLS_PRODUCT;
        else if (t == CHAR_TWO && c == CHAR_A)
            r = CLS_BOOK;
        else if (t == CHAR_TWO && c == CHAR_D)
            r = CLS_TRADE;
        return r;
    endfunction

    assign b      = in_ch.data_byte;
    assign p      = pos_reg;
    assign accept = in_ch.valid && in_ch.ready;

    // class in force for this byte's characters
    assign class_now = at(p, 2) ? class_after_tag(tag_reg, b) : class_reg;

    // count = high nibble * 10 + low nibble
    assign book_count = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'h0, b[3:0]};

    // layout tracking and field classification
    always_comb
    begin
        pos_next     = pos_reg;
        class_next   = class_reg;
        tag_next     = tag_reg;
        groups_next  = groups_reg;
        goff_next    = goff_reg;
        section_next = section_reg;
        toff_next    = toff_reg;
        kind         = K_NONE;

        if (at(p, 1))
        begin
            tag_next = b;
        end
        else if (at(p, 2))
        begin
            if (tag_reg == CHAR_ONE && b == CHAR_ONE)
                class_next = CLS_PRODUCT;
            else if (tag_reg == CHAR_TWO && b == CHAR_A)
                class_next = CLS_BOOK;
            else if (tag_reg == CHAR_TWO && b == CHAR_D)
                class_next = CLS_TRADE;
            else
                class_next = CLS_NONE;
        end
        else if (p > pos_t'(2))
        begin
            unique case (class_reg)
                CLS_NONE:
                begin
                    kind = K_NONE;
                end
                CLS_PRODUCT:
                begin
                    if (in_range(p, 19, 28))
                        kind = at(p, 28) ? K_RAW_COMMA : K_RAW;
                    else if (in_range(p, 29, 63))
                        kind = product_comma(p) ? K_BCD_COMMA : K_BCD;
                end
                CLS_BOOK:
                begin
                    if (section_reg == SEC_HEAD)
                    begin
                        if (p <= pos_t'(43))
                            kind = common_kind(p);
                        else if (at(p, 44))
                        begin
                            groups_next  = book_count;
                            goff_next    = '0;
                            section_next = (book_count != 8'd0) ? SEC_GROUPS : SEC_DONE;
                        end
                    end
                    else if (section_reg == SEC_GROUPS)
                    begin
                        if (goff_reg <= 4'd2)
                            kind = K_RAW_COMMA;
                        else if (goff_reg <= 4'd7)
                            kind = (goff_reg == 4'd7) ? K_BCD_COMMA : K_BCD;
                        else if (goff_reg <= 4'd11)
                            kind = (goff_reg == 4'd11) ? K_BCD_COMMA : K_BCD;
                        else
                            kind = K_BCD_COMMA;
                        if (goff_reg >= 4'd12)
                        begin
                            goff_next   = '0;
                            groups_next = groups_reg - 8'd1;
                            if (groups_reg == 8'd1)
                                section_next = SEC_DONE;
                        end
                        else
                            goff_next = goff_reg + 4'd1;
                    end
                end
                CLS_TRADE:
                begin
                    if (section_reg == SEC_HEAD)
                    begin
                        if (p <= pos_t'(43))
                            kind = common_kind(p);
                        else if (at(p, 44) || at(p, 61))
                            kind = K_RAW_COMMA;
                        else if (in_range(p, 45, 50))
                            kind = at(p, 50) ? K_BCD_COMMA : K_BCD;
                        else if (at(p, 51))
                            kind = K_SIGN_COMMA;
                        else if (in_range(p, 52, 56))
                            kind = at(p, 56) ? K_BCD_COMMA : K_BCD;
                        else if (in_range(p, 57, 60))
                            kind = at(p, 60) ? K_BCD_COMMA : K_BCD;
                        else if (at(p, 62))
                        begin
                            groups_next  = {1'b0, b[6:0]};
                            goff_next    = '0;
                            toff_next    = '0;
                            section_next = (b[6:0] != 7'd0) ? SEC_GROUPS : SEC_TRAILER;
                        end
                    end
                    else if (section_reg == SEC_GROUPS)
                    begin
                        if (goff_reg == 4'd0)
                            kind = K_SIGN_COMMA;
                        else if (goff_reg <= 4'd5)
                            kind = (goff_reg == 4'd5) ? K_BCD_COMMA : K_BCD;
                        else
                            kind = (goff_reg >= 4'd7) ? K_BCD_COMMA : K_BCD;
                        if (goff_reg >= 4'd7)
                        begin
                            goff_next   = '0;
                            groups_next = groups_reg - 8'd1;
                            if (groups_reg == 8'd1)
                                section_next = SEC_TRAILER;
                        end
                        else
                            goff_next = goff_reg + 4'd1;
                    end
                    else if (section_reg == SEC_TRAILER)
                    begin
                        kind = (toff_reg[1:0] == 2'b11) ? K_BCD_COMMA : K_BCD;
                        if (toff_reg >= 4'd11)
                            section_next = SEC_DONE;
                        else
                            toff_next = toff_reg + 4'd1;
                    end
                end
                default:
                begin
                    kind = K_NONE;
                end
            endcase
        end

        // saturating position
        if (p != POS_MAX)
            pos_next = p + pos_t'(1);

        // end of message returns everything to reset
        if (in_ch.last_byte)
        begin
            pos_next     = '0;
            class_next   = CLS_NONE;
            tag_next     = '0;
            groups_next  = '0;
            goff_next    = '0;
            section_next = SEC_HEAD;
            toff_next    = '0;
        end
    end

    // character run for this byte
    always_comb
    begin
        cmd_build = '0;
        n_chars   = 3'd0;
        case (kind)
            K_RAW:
            begin
                cmd_build.chars[0] = b;
                n_chars            = 3'd1;
            end
            K_RAW_COMMA:
            begin
                cmd_build.chars[0] = b;
                cmd_build.chars[1] = CHAR_COMMA;
                n_chars            = 3'd2;
            end
            K_SIGN_COMMA:
            begin
                cmd_build.chars[0] = (b != 8'd0) ? CHAR_MINUS : CHAR_PLUS;
                cmd_build.chars[1] = CHAR_COMMA;
                n_chars            = 3'd2;
            end
            K_BCD:
            begin
                cmd_build.chars[0] = {DIGIT_BASE, b[7:4]};
                cmd_build.chars[1] = {DIGIT_BASE, b[3:0]};
                n_chars            = 3'd2;
            end
            K_BCD_COMMA:
            begin
                cmd_build.chars[0] = {DIGIT_BASE, b[7:4]};
                cmd_build.chars[1] = {DIGIT_BASE, b[3:0]};
                cmd_build.chars[2] = CHAR_COMMA;
                n_chars            = 3'd3;
            end
            default:
            begin
                n_chars = 3'd0;
            end
        endcase

        // newline closes a classified message
        if (in_ch.last_byte && class_now != CLS_NONE)
        begin
            cmd_build.chars[n_chars[1:0]] = CHAR_NEWLINE;
            n_chars                       = n_chars + 3'd1;
        end

        cmd_build.last_idx = 2'(n_chars - 3'd1);
        cmd_build.stream   = 2'(class_now - 2'd1);
    end

    assign in_ch.ready = cmd_ready;
    assign cmd         = cmd_build;
    assign cmd_valid   = accept && (n_chars != 3'd0);

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            class_reg   <= CLS_NONE;
            tag_reg     <= '0;
            groups_reg  <= '0;
            goff_reg    <= '0;
            section_reg <= SEC_HEAD;
            toff_reg    <= '0;
        end
        else if (accept)
        begin
            pos_reg     <= pos_next;
            class_reg   <= class_next;
            tag_reg     <= tag_next;
            groups_reg  <= groups_next;
            goff_reg    <= goff_next;
            section_reg <= section_next;
            toff_reg    <= toff_next;
        end
    end

endmodule

/* src/fmcu_queue.sv */
// fmcu_queue: short fifo of character runs between front and back
// depends on fmcu_pkg
`timescale 1ns / 1ps

module fmcu_queue
    import fmcu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t push_data,
    input  logic push_valid,
    output logic push_ready,
    output cmd_t pop_data,
    output logic pop_valid,
    input  logic pop_ready
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    cmd_t                mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_BITS:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != (PTR_BITS+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_BITS'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_BITS'(1);
        if (do_push && !do_pop)
            count_next = count_reg + (PTR_BITS+1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (PTR_BITS+1)'(1);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* src/fmcu_back.sv */
// fmcu_back: plays out each queued character run, one character per cycle while out_ch is ready
// depends on fmcu_pkg and fmcu_out_if
`timescale 1ns / 1ps

module fmcu_back
    import fmcu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      pop_data,
    input  logic      pop_valid,
    output logic      pop_ready,
    fmcu_out_if.source out_ch
);

    localparam int IDX_BITS = $clog2(MAX_CHARS);

    cmd_t                cmd_reg;
    logic                busy_reg;
    logic [IDX_BITS-1:0] idx_reg;
    logic                final_char;
    logic                take;

    assign final_char = (idx_reg == cmd_reg.last_idx);
    assign take       = out_ch.valid && out_ch.ready;
    assign pop_ready  = !busy_reg || (take && final_char);

    assign out_ch.valid         = busy_reg;
    assign out_ch.out_char      = cmd_reg.chars[idx_reg];
    assign out_ch.stream_select = cmd_reg.stream;
    assign out_ch.last_of_run   = final_char;

    // control: load a run, step through its characters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (pop_ready)
        begin
            busy_reg <= pop_valid;
            idx_reg  <= '0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + IDX_BITS'(1);
        end
    end

    // run payload
    always_ff @(posedge clk)
    begin
        if (pop_ready && pop_valid)
            cmd_reg <= pop_data;
    end

endmodule

/* src/feed_message_csv_unpacker.sv */
// feed_message_csv_unpacker: market feed message payload to csv character stream
// depends on fmcu_pkg, fmcu_in_if, fmcu_out_if, fmcu_front, fmcu_queue, fmcu_back
//
// Usage
//   in_ch takes one payload byte per transaction, last_byte set on the final byte
//   of a message. out_ch gives one csv character per transaction with the target
//   table in stream_select and last_of_run on the final character of a byte.
//   Path: a byte's characters are registered in the run queue and then in the
//   character player's run register before the first one is valid on out_ch.
//   Throughput: one character per cycle on out_ch while out_ch is ready; a byte
//   gives one to four characters (bcd field with comma plus newline).
//   Bytes that give no characters put no run into the queue. The front accepts a
//   byte every cycle while the two-entry run queue has room, so it keeps taking
//   bytes while earlier runs are still being played out.
//   Stall: when out_ch is not ready the current character holds, the queue
//   fills, and in_ch.ready drops once both queue entries are taken.
//   Reset: clears the position, class, group counters and queue; no output is
//   valid until a byte arrives.
`timescale 1ns / 1ps

module feed_message_csv_unpacker
    import fmcu_pkg::*;
#(
    parameter int POSITION_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    fmcu_in_if.sink    in_ch,
    fmcu_out_if.source out_ch
);

    cmd_t front_cmd;
    logic front_valid;
    logic front_ready;
    cmd_t back_cmd;
    logic back_valid;
    logic back_ready;

    // classify bytes and build runs
    fmcu_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    // decoupling queue
    fmcu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_data   (back_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    // play out characters
    fmcu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_data  (back_cmd),
        .pop_valid (back_valid),
        .pop_ready (back_ready),
        .out_ch    (out_ch)
    );

endmodule

/* bench/fmcu_csv_check_pkg.sv */
// fmcu_csv_check_pkg: csv character predictor and scoreboard for the unpacker bench
// depends on fmcu_pkg for the character constants
`timescale 1ns / 1ps

package fmcu_csv_check_pkg;

    import fmcu_pkg::*;

    localparam int POS_BITS = 16;

    typedef enum logic [1:0] {
        CLASS_NONE,
        CLASS_PRODUCT,
        CLASS_BOOK,
        CLASS_TRADE
    } msg_class_t;

    typedef enum logic [1:0] {
        SEC_HEADER,
        SEC_GROUPS,
        SEC_TRAILER,
        SEC_DONE
    } section_t;

    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] stream;
        logic       last;
    } csv_char_t;

    class csv_char_predictor;

        csv_char_t           expected_chars[$];
        logic [7:0]          run_chars[$];
        int                  mismatch_count;

        // message parsing state
        logic [POS_BITS-1:0] byte_pos;
        msg_class_t          msg_class;
        logic [7:0]          tag_byte;
        logic [7:0]          groups_left;
        logic [3:0]          group_offset;
        section_t            section;
        logic [3:0]          trailer_offset;

        function new();
            mismatch_count = 0;
            clear_message();
        endfunction

        function void clear_message();
            byte_pos       = '0;
            msg_class      = CLASS_NONE;
            tag_byte       = 8'h00;
            groups_left    = 8'h00;
            group_offset   = 4'h0;
            section        = SEC_HEADER;
            trailer_offset = 4'h0;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        function void put_char(logic [7:0] c);
            run_chars.push_back(c);
        endfunction

        // two digits, one per nibble, optional comma
        function void put_bcd(logic [7:0] b, bit comma);
            put_char({DIGIT_BASE, b[7:4]});
            put_char({DIGIT_BASE, b[3:0]});
            if (comma)
                put_char(CHAR_COMMA);
        endfunction

        function void put_field(logic [7:0] b);
            put_char(b);
            put_char(CHAR_COMMA);
        endfunction

        function void put_sign(logic [7:0] b);
            put_char((b != 8'h00) ? CHAR_MINUS : CHAR_PLUS);
            put_char(CHAR_COMMA);
        endfunction

        // header bytes 19..43 shared by book and trade layouts
        function void head_fields(int p, logic [7:0] b);
            if (p >= 19 && p <= 38)
            begin
                put_char(b);
                if (p == 38)
                    put_char(CHAR_COMMA);
            end
            else if (p >= 39 && p <= 43)
                put_bcd(b, p == 43);
        endfunction

        function void product_fields(int p, logic [7:0] b);
            if (p >= 19 && p <= 28)
            begin
                put_char(b);
                if (p == 28)
                    put_char(CHAR_COMMA);
            end
            else if (p >= 29 && p <= 63)
                put_bcd(b, ((p - 29) % 5) == 4);
        endfunction

        function void book_fields(int p, logic [7:0] b);
            logic [3:0] o;
            o = group_offset;
            if (section == SEC_HEADER)
            begin
                if (p <= 43)
                    head_fields(p, b);
                else if (p == 44)
                begin
                    // bcd entry count, odd nibbles taken as they are
                    groups_left  = 8'(int'(b[7:4]) * 10 + int'(b[3:0]));
                    group_offset = 4'h0;
                    if (groups_left != 8'h00)
                        section = SEC_GROUPS;
                    else
                        section = SEC_DONE;
                end
            end
            else if (section == SEC_GROUPS)
            begin
                if (o <= 2)
                    put_field(b);
                else if (o <= 7)
                    put_bcd(b, o == 7);
                else if (o <= 11)
                    put_bcd(b, o == 11);
                else
                    put_bcd(b, 1'b1);
                if (o >= 12)
                begin
                    group_offset = 4'h0;
                    groups_left  = groups_left - 8'd1;
                    if (groups_left == 8'h00)
                        section = SEC_DONE;
                end
                else
                    group_offset = o + 4'd1;
            end
        endfunction

        function void trade_fields(int p, logic [7:0] b);
            logic [3:0] o;
            o = group_offset;
            if (section == SEC_HEADER)
            begin
                if (p <= 43)
                    head_fields(p, b);
                else if (p == 44 || p == 61)
                    put_field(b);
                else if (p >= 45 && p <= 50)
                    put_bcd(b, p == 50);
                else if (p == 51)
                    put_sign(b);
                else if (p >= 52 && p <= 56)
                    put_bcd(b, p == 56);
                else if (p >= 57 && p <= 60)
                    put_bcd(b, p == 60);
                else if (p == 62)
                begin
                    groups_left    = {1'b0, b[6:0]};
                    group_offset   = 4'h0;
                    trailer_offset = 4'h0;
                    if (groups_left != 8'h00)
                        section = SEC_GROUPS;
                    else
                        section = SEC_TRAILER;
                end
            end
            else if (section == SEC_GROUPS)
            begin
                if (o == 0)
                    put_sign(b);
                else if (o <= 5)
                    put_bcd(b, o == 5);
                else
                    put_bcd(b, o >= 7);
                if (o >= 7)
                begin
                    group_offset = 4'h0;
                    groups_left  = groups_left - 8'd1;
                    if (groups_left == 8'h00)
                        section = SEC_TRAILER;
                end
                else
                    group_offset = o + 4'd1;
            end
            else if (section == SEC_TRAILER)
            begin
                put_bcd(b, trailer_offset[1:0] == 2'b11);
                if (trailer_offset >= 11)
                    section = SEC_DONE;
                else
                    trailer_offset = trailer_offset + 4'd1;
            end
        endfunction

        // accepted input transaction: work out the characters it causes
        function void take_byte(logic [7:0] b, logic last);
            int         p;
            logic [1:0] stream;
            run_chars.delete();
            p = int'(byte_pos);
            if (p == 1)
                tag_byte = b;
            else if (p == 2)
            begin
                if (tag_byte == CHAR_ONE && b == CHAR_ONE)
                    msg_class = CLASS_PRODUCT;
                else if (tag_byte == CHAR_TWO && b == CHAR_A)
                    msg_class = CLASS_BOOK;
                else if (tag_byte == CHAR_TWO && b == CHAR_D)
                    msg_class = CLASS_TRADE;
                else
                    msg_class = CLASS_NONE;
            end
            else if (p > 2)
            begin
                case (msg_class)
                    CLASS_PRODUCT: product_fields(p, b);
                    CLASS_BOOK:    book_fields(p, b);
                    CLASS_TRADE:   trade_fields(p, b);
                    default:       ;
                endcase
            end
            stream = 2'(int'(msg_class) - 1);
            if (last && msg_class != CLASS_NONE)
                put_char(CHAR_NEWLINE);
            // position saturates instead of wrapping
            if (byte_pos != '1)
                byte_pos = byte_pos + 1'b1;
            if (last)
                clear_message();
            foreach (run_chars[k])
                expected_chars.push_back('{run_chars[k], stream, k == run_chars.size() - 1});
        endfunction

        // accepted output transaction against the oldest expectation
        function void check_char(logic [7:0] ch, logic [1:0] stream, logic last);
            csv_char_t want;
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected char: expected none, actual %h stream %0d last %0d",
                         $time, ch, stream, last);
                mismatch_count++;
                return;
            end
            want = expected_chars.pop_front();
            if (want.ch !== ch)
            begin
                $display("%0t: out_char mismatch: expected %h, actual %h", $time, want.ch, ch);
                mismatch_count++;
            end
            if (want.stream !== stream)
            begin
                $display("%0t: stream_select mismatch: expected %0d, actual %0d",
                         $time, want.stream, stream);
                mismatch_count++;
            end
            if (want.last !== last)
            begin
                $display("%0t: last_of_run mismatch: expected %0d, actual %0d",
                         $time, want.last, last);
                mismatch_count++;
            end
        endfunction

    endclass

endpackage

/* bench/feed_message_csv_unpacker_test.sv */
// feed_message_csv_unpacker_test: drives feed messages into the unpacker and
// checks every csv character; depends on fmcu_pkg, fmcu_in_if, fmcu_out_if,
// fmcu_csv_check_pkg and feed_message_csv_unpacker
`timescale 1ns / 1ps

module feed_message_csv_unpacker_test;

    import fmcu_pkg::*;
    import fmcu_csv_check_pkg::*;

    typedef enum int {
        KIND_PRODUCT,
        KIND_BOOK,
        KIND_TRADE,
        KIND_OTHER
    } msg_kind_t;

    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20000;

    logic clk = 1'b0;
    logic rst_n;

    fmcu_in_if  in_ch();
    fmcu_out_if out_ch();

    csv_char_predictor sb;
    logic [7:0]        msg_q[$];
    bit                idle_on;
    bit                hold_request;

    feed_message_csv_unpacker #(
        .POSITION_BITS(POS_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #5 clk = ~clk;

    // gap length: mostly none or short, now and then long
    function automatic int idle_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // fill msg_q with one payload; cut > 0 truncates, cut < 0 truncates at random
    function automatic void build_message(msg_kind_t kind, logic [7:0] count_byte,
                                          int extra, int cut);
        int         body_len;
        int         n;
        int         r;
        logic [7:0] t1;
        logic [7:0] t2;
        case (kind)
            KIND_PRODUCT:
            begin
                t1 = CHAR_ONE;
                t2 = CHAR_ONE;
                body_len = 64;
            end
            KIND_BOOK:
            begin
                t1 = CHAR_TWO;
                t2 = CHAR_A;
                n = (int'(count_byte[7:4]) * 10 + int'(count_byte[3:0])) % 256;
                body_len = 45 + 13 * n;
            end
            KIND_TRADE:
            begin
                t1 = CHAR_TWO;
                t2 = CHAR_D;
                n = int'(count_byte[6:0]);
                body_len = 63 + 8 * n + 12;
            end
            default:
            begin
                // near misses of the known tags plus plain noise
                do
                begin
                    r  = $urandom_range(0, 2);
                    t1 = (r == 0) ? CHAR_ONE : (r == 1) ? CHAR_TWO : 8'($urandom_range(0, 255));
                    r  = $urandom_range(0, 3);
                    t2 = (r == 0) ? CHAR_ONE : (r == 1) ? CHAR_A :
                         (r == 2) ? CHAR_D : 8'($urandom_range(0, 255));
                end
                while ((t1 == CHAR_ONE && t2 == CHAR_ONE) ||
                       (t1 == CHAR_TWO && (t2 == CHAR_A || t2 == CHAR_D)));
                body_len = $urandom_range(3, 80);
            end
        endcase
        msg_q.delete();
        for (int i = 0; i < body_len + extra; i++)
        begin
            r = $urandom_range(0, 7);
            if (r == 0)
                msg_q.push_back(8'h00);
            else if (r == 1)
                msg_q.push_back(8'hFF);
            else
                msg_q.push_back(8'($urandom_range(0, 255)));
        end
        msg_q[1] = t1;
        msg_q[2] = t2;
        if (kind == KIND_BOOK)
            msg_q[44] = count_byte;
        else if (kind == KIND_TRADE)
            msg_q[62] = count_byte;
        if (cut < 0)
            cut = $urandom_range(1, msg_q.size() - 1);
        if (cut > 0 && cut < msg_q.size())
            msg_q = msg_q[0:cut-1];
    endfunction

    // one input transaction, entered and left at a falling edge
    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.take_byte(b, last);
        @(negedge clk);
    endtask

    task automatic send_message();
        foreach (msg_q[i])
            send_byte(msg_q[i], i == msg_q.size() - 1);
    endtask

    // sender pauses until every expected character has come out
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int stall_left;
        int gap;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                stall_left = 0;
            end
            else if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                gap = idle_gap();
                if (gap == 0)
                    out_ch.ready <= 1'b1;
                else
                begin
                    out_ch.ready <= 1'b0;
                    stall_left = gap - 1;
                end
            end
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            sb.check_char(out_ch.out_char, out_ch.stream_select, out_ch.last_of_run);
    end

    // run limit
    initial
    begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // stimulus
    initial
    begin
        int waited;
        sb              = new();
        idle_on         = 1'b1;
        hold_request    = 1'b0;
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.last_byte = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // message ends before classification, then right at it
        build_message(KIND_PRODUCT, 8'h00, 0, 1);
        send_message();
        build_message(KIND_BOOK, 8'h00, 0, 2);
        send_message();
        build_message(KIND_PRODUCT, 8'h00, 0, 3);
        send_message();
        // unknown tag gives nothing
        build_message(KIND_OTHER, 8'h00, 0, 4);
        send_message();
        // product raw field and first bcd byte
        build_message(KIND_PRODUCT, 8'h00, 0, 30);
        send_message();
        // book header, odd count, first entry bytes
        build_message(KIND_BOOK, 8'h01, 0, 47);
        send_message();

        // receiver holds off while the sender keeps offering; zero item count
        idle_on      = 1'b0;
        hold_request = 1'b1;
        build_message(KIND_TRADE, 8'h80, 0, 64);
        send_message();
        wait_drained();
        idle_on = 1'b1;

        // wait for the last characters, then check that none are left outstanding
        in_ch.valid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $display("%0t: %0d expected chars never came out", $time, sb.pending());
            sb.mismatch_count++;
        end
        if (sb.mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
